### rtl/core/ray_capped_cylinder_intersection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray against capped cylinder block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RAY_CAPPED_CYLINDER_INTERSECTION_ASSERT_SVH
`define RAY_CAPPED_CYLINDER_INTERSECTION_ASSERT_SVH

// Overlapping implication checked on every clock edge out of reset.
`define RCCI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rcci port check failed");

// Non-overlapping implication: the consequent is checked in the cycle after the trigger.
`define RCCI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rcci port check failed");

`endif

### rtl/core/rcci_pkg.sv
// ----------------------------------------------------------------------------
// Ray capped cylinder package
// Widths, constants, pipeline context type and helpers shared by the design and test files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcci_pkg;

	localparam int CW    = 32;
	localparam int FB    = 16;
	localparam int AW    = 2 * CW;
	localparam int BW    = 2 * CW + 2;
	localparam int NUMW  = BW + 2;
	localparam int SQ    = 2 * CW + 1;
	localparam int RW    = 2 * SQ;
	localparam int SREM  = SQ + 3;
	localparam int NW    = 2 * CW + FB + 4;
	localparam int TW    = NW + 1;
	localparam int MW    = NW;
	localparam int MD    = 16;
	localparam int MC    = (MW + MD - 1) / MD;
	localparam int BPW   = MC * MD;
	localparam int PW    = 2 * MW;
	localparam int DW    = 4 * CW + 4;
	localparam int ZW    = PW + 2;
	localparam int LANES = 3;
	localparam int DL    = 2;
	localparam int LATENCY = 7 + 3 * MC + SQ + NW;

	typedef logic [MW-1:0] mag_t;
	typedef logic [PW-1:0] prod_t;

	typedef struct packed {
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic signed [CW-1:0] oz;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
		logic [AW-1:0]        a;
		logic signed [BW-1:0] b;
		logic                 disc_neg;
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] t2;
		logic                 side_ok;
	} ctx_t;

	localparam logic SURF_SIDE = 1'b0;
	localparam logic SURF_CAP  = 1'b1;

	localparam logic signed [CW-1:0] DIST_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] DIST_MIN = {1'b1, {(CW - 1){1'b0}}};
	localparam logic signed [BW-1:0] ONE2_B   = BW'(1) << (2 * FB);
	localparam logic signed [CW+1:0] ONE_E    = (CW + 2)'(1) << FB;
	localparam logic signed [ZW-1:0] ONE2_Z   = ZW'(1) << (2 * FB);
	localparam logic [PW:0]          ONE4     = (PW + 1)'(1) << (4 * FB);

	function automatic mag_t mag_of(input logic signed [ZW-1:0] v);
		logic signed [ZW-1:0] p;
		p = v[ZW-1] ? -v : v;
		return p[MW-1:0];
	endfunction

endpackage

### rtl/core/ray_capped_cylinder_intersection.sv
// Between an accepted start and done lie three multiplier rows of 6 cells each,
// a square root row of 65 cells and a divider row of 84 cells.
// Throughput: one ray item per cycle; busy stays low, so start may be high every cycle.
// Each item gives exactly one result, shown for one cycle with done high.
// Reset clears only the valid bits of the pipeline; items in flight are dropped.
// ----------------------------------------------------------------------------
// Ray against unit capped cylinder
// Pipelined fixed point intersection of a ray with the capped cylinder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_capped_cylinder_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [rcci_pkg::CW-1:0] origin_x,
	input  logic signed [rcci_pkg::CW-1:0] origin_y,
	input  logic signed [rcci_pkg::CW-1:0] origin_z,
	input  logic signed [rcci_pkg::CW-1:0] dir_x,
	input  logic signed [rcci_pkg::CW-1:0] dir_y,
	input  logic signed [rcci_pkg::CW-1:0] dir_z,
	output logic                          done,
	output logic                          hit,
	output logic                          surface,
	output logic signed [rcci_pkg::CW-1:0] distance,
	output logic                          clipped
);

	localparam int CW = rcci_pkg::CW;
	localparam int FB = rcci_pkg::FB;
	localparam int AW = rcci_pkg::AW;
	localparam int BW = rcci_pkg::BW;
	localparam int NUMW = rcci_pkg::NUMW;
	localparam int NW = rcci_pkg::NW;
	localparam int TW = rcci_pkg::TW;
	localparam int PW = rcci_pkg::PW;
	localparam int DW = rcci_pkg::DW;
	localparam int ZW = rcci_pkg::ZW;
	localparam int RW = rcci_pkg::RW;
	localparam int SQ = rcci_pkg::SQ;
	localparam int LANES = rcci_pkg::LANES;
	localparam int DL = rcci_pkg::DL;

	// Stage 1: coordinate products.
	logic                 vld_s1;
	rcci_pkg::ctx_t       ctx_s1;
	logic signed [AW-1:0] dxx_s1, dyy_s1, oxdx_s1, oydy_s1, oxx_s1, oyy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1  <= '{ox: origin_x, oy: origin_y, oz: origin_z, dx: dir_x, dy: dir_y,
			dz: dir_z, default: '0};
		dxx_s1  <= dir_x * dir_x;
		dyy_s1  <= dir_y * dir_y;
		oxdx_s1 <= origin_x * dir_x;
		oydy_s1 <= origin_y * dir_y;
		oxx_s1  <= origin_x * origin_x;
		oyy_s1  <= origin_y * origin_y;
	end

	// Stage 2: quadratic coefficients.
	logic                 vld_s2;
	rcci_pkg::ctx_t       cx2_c;
	rcci_pkg::ctx_t       ctx_s2;
	logic signed [BW-1:0] c_s2;

	always_comb begin
		cx2_c   = ctx_s1;
		cx2_c.a = AW'(dxx_s1) + AW'(dyy_s1);
		cx2_c.b = BW'(oxdx_s1) + BW'(oydy_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2   <= cx2_c;
		c_s2     <= BW'(oxx_s1) + BW'(oyy_s1) - rcci_pkg::ONE2_B;
	end

	// Products b*b and a*c.
	rcci_pkg::mag_t  m1_a [LANES];
	rcci_pkg::mag_t  m1_b [LANES];
	logic            m1_n [LANES];
	logic            vld_m1;
	rcci_pkg::ctx_t  ctx_m1;
	rcci_pkg::prod_t m1_p [LANES];
	logic            m1_pn [LANES];

	always_comb begin
		m1_a[0] = rcci_pkg::mag_of(ZW'(ctx_s2.b));
		m1_b[0] = rcci_pkg::mag_of(ZW'(ctx_s2.b));
		m1_n[0] = 1'b0;
		m1_a[1] = rcci_pkg::MW'(ctx_s2.a);
		m1_b[1] = rcci_pkg::mag_of(ZW'(c_s2));
		m1_n[1] = c_s2[BW-1];
		m1_a[2] = '0;
		m1_b[2] = '0;
		m1_n[2] = 1'b0;
	end

	rcci_mul u_mul1 (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s2), .ctx_in(ctx_s2),
		.a_in(m1_a), .b_in(m1_b), .neg_in(m1_n),
		.vld_out(vld_m1), .ctx_out(ctx_m1), .prod_out(m1_p), .neg_out(m1_pn)
	);

	// Stage 3: discriminant.
	logic signed [DW-1:0] bb_c, ac_c, disc_c;
	rcci_pkg::ctx_t       cx3_c;
	logic                 vld_s3;
	rcci_pkg::ctx_t       ctx_s3;
	logic [RW-1:0]        rad_s3;

	always_comb begin
		bb_c   = signed'(m1_p[0][DW-1:0]);
		ac_c   = signed'(m1_p[1][DW-1:0]);
		disc_c = m1_pn[1] ? bb_c + ac_c : bb_c - ac_c;
		cx3_c  = ctx_m1;
		cx3_c.disc_neg = disc_c[DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3          <= cx3_c;
		rad_s3          <= disc_c[DW-1] ? '0 : disc_c[RW-1:0];
	end

	logic           vld_sq;
	rcci_pkg::ctx_t ctx_sq;
	logic [SQ-1:0]  root_sq;

	rcci_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s3), .ctx_in(ctx_s3), .rad_in(rad_s3),
		.vld_out(vld_sq), .ctx_out(ctx_sq), .root_out(root_sq)
	);

	// Stage 4: dividends and divisors for the side root and the cap plane.
	logic signed [NUMW-1:0] num_c;
	logic signed [CW+1:0]   capz_c, diff_c;
	logic                   vld_s4;
	rcci_pkg::ctx_t         ctx_s4;
	logic [NW-1:0]          dn_s4 [DL];
	logic [AW-1:0]          dd_s4 [DL];
	logic                   dg_s4 [DL];

	always_comb begin
		num_c  = -(NUMW'(ctx_sq.b) + signed'(NUMW'(root_sq)));
		capz_c = ctx_sq.oz[CW-1] ? -rcci_pkg::ONE_E : rcci_pkg::ONE_E;
		diff_c = capz_c - (CW + 2)'(ctx_sq.oz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s4   <= ctx_sq;
		dn_s4[0] <= rcci_pkg::mag_of(ZW'(num_c)) << FB;
		dd_s4[0] <= ctx_sq.a;
		dg_s4[0] <= num_c[NUMW-1];
		dn_s4[1] <= rcci_pkg::mag_of(ZW'(diff_c)) << FB;
		dd_s4[1] <= AW'(rcci_pkg::mag_of(ZW'(ctx_sq.dz)));
		dg_s4[1] <= diff_c[CW+1] ^ ctx_sq.dz[CW-1];
	end

	logic           vld_dv;
	rcci_pkg::ctx_t ctx_dv;
	logic [NW-1:0]  quo_dv [DL];
	logic           rnz_dv [DL];
	logic           neg_dv [DL];

	rcci_div u_div (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s4), .ctx_in(ctx_s4),
		.num_in(dn_s4), .den_in(dd_s4), .neg_in(dg_s4),
		.vld_out(vld_dv), .ctx_out(ctx_dv), .quo_out(quo_dv), .rnz_out(rnz_dv),
		.neg_out(neg_dv)
	);

	// Stage 5: floor rounding of both ray parameters.
	logic signed [TW-1:0] tq_c [DL];
	rcci_pkg::ctx_t       cx5_c;
	logic                 vld_s5;
	rcci_pkg::ctx_t       ctx_s5;

	always_comb begin
		for (int i = 0; i < DL; i++) begin
			tq_c[i] = neg_dv[i] ? -(TW'(quo_dv[i]) + TW'(rnz_dv[i])) : TW'(quo_dv[i]);
		end
		cx5_c    = ctx_dv;
		cx5_c.t  = tq_c[0];
		cx5_c.t2 = tq_c[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s5    <= cx5_c;
	end

	// Products t*dz, t2*dx and t2*dy.
	rcci_pkg::mag_t  m2_a [LANES];
	rcci_pkg::mag_t  m2_b [LANES];
	logic            m2_n [LANES];
	logic            vld_m2;
	rcci_pkg::ctx_t  ctx_m2;
	rcci_pkg::prod_t m2_p [LANES];
	logic            m2_pn [LANES];

	always_comb begin
		m2_a[0] = rcci_pkg::mag_of(ZW'(ctx_s5.t));
		m2_b[0] = rcci_pkg::mag_of(ZW'(ctx_s5.dz));
		m2_n[0] = ctx_s5.t[TW-1] ^ ctx_s5.dz[CW-1];
		m2_a[1] = rcci_pkg::mag_of(ZW'(ctx_s5.t2));
		m2_b[1] = rcci_pkg::mag_of(ZW'(ctx_s5.dx));
		m2_n[1] = ctx_s5.t2[TW-1] ^ ctx_s5.dx[CW-1];
		m2_a[2] = rcci_pkg::mag_of(ZW'(ctx_s5.t2));
		m2_b[2] = rcci_pkg::mag_of(ZW'(ctx_s5.dy));
		m2_n[2] = ctx_s5.t2[TW-1] ^ ctx_s5.dy[CW-1];
	end

	rcci_mul u_mul2 (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s5), .ctx_in(ctx_s5),
		.a_in(m2_a), .b_in(m2_b), .neg_in(m2_n),
		.vld_out(vld_m2), .ctx_out(ctx_m2), .prod_out(m2_p), .neg_out(m2_pn)
	);

	// Stage 6: side z test and cap hit point.
	logic signed [ZW-1:0] sp_c [LANES];
	logic signed [ZW-1:0] z2_c, x2_c, y2_c;
	rcci_pkg::ctx_t       cx6_c;
	logic                 vld_s6;
	rcci_pkg::ctx_t       ctx_s6;
	rcci_pkg::mag_t       xm_s6, ym_s6;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sp_c[i] = m2_pn[i] ? -signed'(ZW'(m2_p[i])) : signed'(ZW'(m2_p[i]));
		end
		z2_c = (ZW'(ctx_m2.oz) <<< FB) + sp_c[0];
		x2_c = (ZW'(ctx_m2.ox) <<< FB) + sp_c[1];
		y2_c = (ZW'(ctx_m2.oy) <<< FB) + sp_c[2];
		cx6_c = ctx_m2;
		cx6_c.side_ok = (ctx_m2.a != '0) && (z2_c <= rcci_pkg::ONE2_Z) &&
			(z2_c >= -rcci_pkg::ONE2_Z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_m2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s6         <= cx6_c;
		xm_s6          <= rcci_pkg::mag_of(x2_c);
		ym_s6          <= rcci_pkg::mag_of(y2_c);
	end

	// Squares of the cap hit point.
	rcci_pkg::mag_t  m3_a [LANES];
	logic            m3_n [LANES];
	logic            vld_m3;
	rcci_pkg::ctx_t  ctx_m3;
	rcci_pkg::prod_t m3_p [LANES];
	logic            m3_pn [LANES];

	always_comb begin
		m3_a[0] = xm_s6;
		m3_a[1] = ym_s6;
		m3_a[2] = '0;
		for (int i = 0; i < LANES; i++) begin
			m3_n[i] = 1'b0;
		end
	end

	rcci_mul u_mul3 (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s6), .ctx_in(ctx_s6),
		.a_in(m3_a), .b_in(m3_a), .neg_in(m3_n),
		.vld_out(vld_m3), .ctx_out(ctx_m3), .prod_out(m3_p), .neg_out(m3_pn)
	);

	// Stage 7: decision, saturation and result register.
	logic [PW:0]          r2_c;
	logic                 rhit_c, rsurf_c, rclip_c;
	logic signed [TW-1:0] rt_c;
	logic signed [CW-1:0] rdist_c;
	logic                 done_q, hit_q, surface_q, clipped_q;
	logic signed [CW-1:0] distance_q;

	always_comb begin
		r2_c    = (PW + 1)'(m3_p[0]) + (PW + 1)'(m3_p[1]);
		rhit_c  = 1'b0;
		rsurf_c = rcci_pkg::SURF_SIDE;
		rt_c    = ctx_m3.t;
		if (ctx_m3.disc_neg || m3_pn[2]) begin
			rhit_c = 1'b0;
		end else if (ctx_m3.side_ok) begin
			rhit_c = 1'b1;
		end else if (ctx_m3.dz == '0) begin
			rhit_c = 1'b0;
		end else if (r2_c <= rcci_pkg::ONE4) begin
			rhit_c  = 1'b1;
			rsurf_c = rcci_pkg::SURF_CAP;
			rt_c    = ctx_m3.t2;
		end
		if (!rhit_c) begin
			rdist_c = rcci_pkg::DIST_MAX;
			rclip_c = 1'b1;
		end else if (rt_c > TW'(rcci_pkg::DIST_MAX)) begin
			rdist_c = rcci_pkg::DIST_MAX;
			rclip_c = 1'b1;
		end else if (rt_c < TW'(rcci_pkg::DIST_MIN)) begin
			rdist_c = rcci_pkg::DIST_MIN;
			rclip_c = 1'b1;
		end else begin
			rdist_c = rt_c[CW-1:0];
			rclip_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_m3;
		end
	end

	always_ff @(posedge clk) begin
		hit_q      <= rhit_c;
		surface_q  <= rsurf_c;
		distance_q <= rdist_c;
		clipped_q  <= rclip_c;
	end

	assign busy     = 1'b0;
	assign done     = done_q;
	assign hit      = hit_q;
	assign surface  = surface_q;
	assign distance = distance_q;
	assign clipped  = clipped_q;

endmodule

### rtl/core/rcci_mul.sv
// ----------------------------------------------------------------------------
// Digit serial multiplier row
// Three magnitude products formed by a chain of cells, one digit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcci_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	input  rcci_pkg::ctx_t        ctx_in,
	input  rcci_pkg::mag_t        a_in [rcci_pkg::LANES],
	input  rcci_pkg::mag_t        b_in [rcci_pkg::LANES],
	input  logic                  neg_in [rcci_pkg::LANES],
	output logic                  vld_out,
	output rcci_pkg::ctx_t        ctx_out,
	output rcci_pkg::prod_t       prod_out [rcci_pkg::LANES],
	output logic                  neg_out [rcci_pkg::LANES]
);

	typedef struct packed {
		rcci_pkg::mag_t              a;
		logic [rcci_pkg::BPW-1:0]    b;
		rcci_pkg::prod_t             acc;
		logic                        neg;
	} mlane_t;

	logic           vld_q  [1:rcci_pkg::MC];
	rcci_pkg::ctx_t ctx_q  [1:rcci_pkg::MC];
	mlane_t         lane_q [1:rcci_pkg::MC][rcci_pkg::LANES];

	genvar k, l;
	for (k = 0; k < rcci_pkg::MC; k++) begin : g_cell
		logic           vld_c;
		rcci_pkg::ctx_t ctx_c;
		mlane_t         lane_c [rcci_pkg::LANES];

		if (k == 0) begin : g_head
			assign vld_c = vld_in;
			assign ctx_c = ctx_in;
			for (l = 0; l < rcci_pkg::LANES; l++) begin : g_load
				assign lane_c[l] = '{a: a_in[l], b: rcci_pkg::BPW'(b_in[l]), acc: '0,
					neg: neg_in[l]};
			end
		end else begin : g_body
			assign vld_c  = vld_q[k];
			assign ctx_c  = ctx_q[k];
			assign lane_c = lane_q[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			ctx_q[k+1] <= ctx_c;
			for (int i = 0; i < rcci_pkg::LANES; i++) begin
				lane_q[k+1][i] <= '{
					a:   lane_c[i].a,
					b:   lane_c[i].b,
					acc: lane_c[i].acc + (rcci_pkg::prod_t'(
						(rcci_pkg::MW + rcci_pkg::MD)'(lane_c[i].a) *
						(rcci_pkg::MW + rcci_pkg::MD)'(lane_c[i].b[k*rcci_pkg::MD +: rcci_pkg::MD]))
						<< (k * rcci_pkg::MD)),
					neg: lane_c[i].neg
				};
			end
		end
	end

	assign vld_out = vld_q[rcci_pkg::MC];
	assign ctx_out = ctx_q[rcci_pkg::MC];
	for (l = 0; l < rcci_pkg::LANES; l++) begin : g_out
		assign prod_out[l] = lane_q[rcci_pkg::MC][l].acc;
		assign neg_out[l]  = lane_q[rcci_pkg::MC][l].neg;
	end

endmodule

### rtl/core/rcci_sqrt.sv
// ----------------------------------------------------------------------------
// Square root cell row
// Floor square root of the discriminant, one root bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcci_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld_in,
	input  rcci_pkg::ctx_t          ctx_in,
	input  logic [rcci_pkg::RW-1:0] rad_in,
	output logic                    vld_out,
	output rcci_pkg::ctx_t          ctx_out,
	output logic [rcci_pkg::SQ-1:0] root_out
);

	typedef struct packed {
		logic [rcci_pkg::RW-1:0]   rad;
		logic [rcci_pkg::SREM-1:0] rem;
		logic [rcci_pkg::SQ-1:0]   root;
	} sq_t;

	logic           vld_q [1:rcci_pkg::SQ];
	rcci_pkg::ctx_t ctx_q [1:rcci_pkg::SQ];
	sq_t            sq_q  [1:rcci_pkg::SQ];

	genvar k;
	for (k = 0; k < rcci_pkg::SQ; k++) begin : g_cell
		logic                      vld_c;
		rcci_pkg::ctx_t            ctx_c;
		sq_t                       sq_c;
		logic [rcci_pkg::SREM-1:0] rem2;
		logic [rcci_pkg::SREM-1:0] trial;
		logic                      ge;

		if (k == 0) begin : g_head
			assign vld_c = vld_in;
			assign ctx_c = ctx_in;
			assign sq_c  = '{rad: rad_in, rem: '0, root: '0};
		end else begin : g_body
			assign vld_c = vld_q[k];
			assign ctx_c = ctx_q[k];
			assign sq_c  = sq_q[k];
		end

		assign rem2  = {sq_c.rem[rcci_pkg::SREM-3:0], sq_c.rad[rcci_pkg::RW-1 -: 2]};
		assign trial = rcci_pkg::SREM'({sq_c.root, 2'b01});
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			ctx_q[k+1] <= ctx_c;
			sq_q[k+1]  <= '{
				rad:  sq_c.rad << 2,
				rem:  ge ? rem2 - trial : rem2,
				root: {sq_c.root[rcci_pkg::SQ-2:0], ge}
			};
		end
	end

	assign vld_out  = vld_q[rcci_pkg::SQ];
	assign ctx_out  = ctx_q[rcci_pkg::SQ];
	assign root_out = sq_q[rcci_pkg::SQ].root;

endmodule

### rtl/core/rcci_div.sv
// ----------------------------------------------------------------------------
// Restoring divider cell row
// Two magnitude divisions side by side, one quotient bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcci_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld_in,
	input  rcci_pkg::ctx_t          ctx_in,
	input  logic [rcci_pkg::NW-1:0] num_in [rcci_pkg::DL],
	input  logic [rcci_pkg::AW-1:0] den_in [rcci_pkg::DL],
	input  logic                    neg_in [rcci_pkg::DL],
	output logic                    vld_out,
	output rcci_pkg::ctx_t          ctx_out,
	output logic [rcci_pkg::NW-1:0] quo_out [rcci_pkg::DL],
	output logic                    rnz_out [rcci_pkg::DL],
	output logic                    neg_out [rcci_pkg::DL]
);

	typedef struct packed {
		logic [rcci_pkg::NW-1:0] n;
		logic [rcci_pkg::AW-1:0] d;
		logic [rcci_pkg::AW:0]   r;
		logic [rcci_pkg::NW-1:0] q;
		logic                    neg;
	} dv_t;

	logic           vld_q [1:rcci_pkg::NW];
	rcci_pkg::ctx_t ctx_q [1:rcci_pkg::NW];
	dv_t            dv_q  [1:rcci_pkg::NW][rcci_pkg::DL];

	genvar k, l;
	for (k = 0; k < rcci_pkg::NW; k++) begin : g_cell
		logic           vld_c;
		rcci_pkg::ctx_t ctx_c;
		dv_t            dv_c [rcci_pkg::DL];

		if (k == 0) begin : g_head
			assign vld_c = vld_in;
			assign ctx_c = ctx_in;
			for (l = 0; l < rcci_pkg::DL; l++) begin : g_load
				assign dv_c[l] = '{n: num_in[l], d: den_in[l], r: '0, q: '0, neg: neg_in[l]};
			end
		end else begin : g_body
			assign vld_c = vld_q[k];
			assign ctx_c = ctx_q[k];
			assign dv_c  = dv_q[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			logic [rcci_pkg::AW:0] r2;
			logic                  ge;
			ctx_q[k+1] <= ctx_c;
			for (int i = 0; i < rcci_pkg::DL; i++) begin
				r2 = {dv_c[i].r[rcci_pkg::AW-1:0], dv_c[i].n[rcci_pkg::NW-1]};
				ge = r2 >= {1'b0, dv_c[i].d};
				dv_q[k+1][i] <= '{
					n:   dv_c[i].n << 1,
					d:   dv_c[i].d,
					r:   ge ? r2 - {1'b0, dv_c[i].d} : r2,
					q:   {dv_c[i].q[rcci_pkg::NW-2:0], ge},
					neg: dv_c[i].neg
				};
			end
		end
	end

	assign vld_out = vld_q[rcci_pkg::NW];
	assign ctx_out = ctx_q[rcci_pkg::NW];
	for (l = 0; l < rcci_pkg::DL; l++) begin : g_out
		assign quo_out[l] = dv_q[rcci_pkg::NW][l].q;
		assign rnz_out[l] = |dv_q[rcci_pkg::NW][l].r;
		assign neg_out[l] = dv_q[rcci_pkg::NW][l].neg;
	end

endmodule

### rtl/core/rcci_checker.sv
// ----------------------------------------------------------------------------
// Ray capped cylinder port checker
// Watches the top level ports for result encoding and timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ray_capped_cylinder_intersection_assert.svh"

module rcci_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           hit,
	input logic                           surface,
	input logic signed [rcci_pkg::CW-1:0] distance,
	input logic                           clipped
);

	`RCCI_ASSERT_NXT(a_never_busy, clk, arst_n, 1'b1, !busy)
	`RCCI_ASSERT_IMP(a_miss_code, clk, arst_n, done && !hit, !surface && clipped && distance == rcci_pkg::DIST_MAX)
	`RCCI_ASSERT_IMP(a_clip_rail, clk, arst_n, done && clipped, distance == rcci_pkg::DIST_MAX || distance == rcci_pkg::DIST_MIN)
	`RCCI_ASSERT_IMP(a_done_cause, clk, arst_n, done, $past(start, rcci_pkg::LATENCY))

endmodule

bind ray_capped_cylinder_intersection rcci_checker u_rcci_checker (.*);

### tb/sv/tb_checker.sv
// ----------------------------------------------------------------------------
// Ray capped cylinder result checker
// Watches accepted ray items and done strobes, predicts each result with
// exact wide arithmetic and compares every field in order of acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic signed [rcci_pkg::CW-1:0] origin_x,
	input  logic signed [rcci_pkg::CW-1:0] origin_y,
	input  logic signed [rcci_pkg::CW-1:0] origin_z,
	input  logic signed [rcci_pkg::CW-1:0] dir_x,
	input  logic signed [rcci_pkg::CW-1:0] dir_y,
	input  logic signed [rcci_pkg::CW-1:0] dir_z,
	input  logic                           done,
	input  logic                           hit,
	input  logic                           surface,
	input  logic signed [rcci_pkg::CW-1:0] distance,
	input  logic                           clipped,
	output int                             mismatches,
	output int                             pending
);

	localparam int CW = rcci_pkg::CW;
	localparam int FB = rcci_pkg::FB;
	localparam logic signed [CW-1:0] DIST_MAX = rcci_pkg::DIST_MAX;
	localparam logic signed [CW-1:0] DIST_MIN = rcci_pkg::DIST_MIN;
	localparam logic SURF_SIDE = rcci_pkg::SURF_SIDE;
	localparam logic SURF_CAP  = rcci_pkg::SURF_CAP;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic                 hit;
		logic                 surface;
		logic signed [CW-1:0] distance;
		logic                 clipped;
	} hit_rec_t;

	hit_rec_t expected_hits[$];
	int       mismatch_count = 0;

	function automatic wide_t floor_div(input wide_t n, input wide_t d);
		wide_t q;
		wide_t r;
		q = n / d;
		r = n % d;
		if (r != 0 && ((r < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic wide_t floor_sqrt(input wide_t v);
		wide_t r;
		wide_t tr;
		r = 0;
		for (int i = 127; i >= 0; i--) begin
			tr = r | (wide_t'(1) <<< i);
			if (tr * tr <= v)
				r = tr;
		end
		return r;
	endfunction

	function automatic hit_rec_t make_hit(input logic surf, input wide_t t);
		hit_rec_t h;
		h.hit = 1'b1;
		h.surface = surf;
		h.clipped = 1'b0;
		if (t > wide_t'(DIST_MAX)) begin
			h.distance = DIST_MAX;
			h.clipped = 1'b1;
		end else if (t < wide_t'(DIST_MIN)) begin
			h.distance = DIST_MIN;
			h.clipped = 1'b1;
		end else begin
			h.distance = t[CW-1:0];
		end
		return h;
	endfunction

	function automatic hit_rec_t intersect_ray(input logic signed [CW-1:0] pox,
			input logic signed [CW-1:0] poy, input logic signed [CW-1:0] poz,
			input logic signed [CW-1:0] pdx, input logic signed [CW-1:0] pdy,
			input logic signed [CW-1:0] pdz);
		wide_t ox, oy, oz, dx, dy, dz, one, one2;
		wide_t a, b, c, disc, s, t, z2, lid, t2, x2, y2;
		hit_rec_t miss;
		ox = wide_t'(pox);
		oy = wide_t'(poy);
		oz = wide_t'(poz);
		dx = wide_t'(pdx);
		dy = wide_t'(pdy);
		dz = wide_t'(pdz);
		one = wide_t'(1) <<< FB;
		one2 = wide_t'(1) <<< (2 * FB);
		miss = '{hit: 1'b0, surface: SURF_SIDE, distance: DIST_MAX, clipped: 1'b1};
		a = dx * dx + dy * dy;
		b = ox * dx + oy * dy;
		c = ox * ox + oy * oy - one2;
		disc = b * b - a * c;
		if (disc < 0)
			return miss;
		if (a != 0) begin
			s = floor_sqrt(disc);
			t = floor_div(-(b + s) * one, a);
			z2 = oz * one + t * dz;
			if (z2 <= one2 && z2 >= -one2)
				return make_hit(SURF_SIDE, t);
		end
		if (dz == 0)
			return miss;
		lid = (oz < 0) ? -one : one;
		t2 = floor_div((lid - oz) * one, dz);
		x2 = ox * one + t2 * dx;
		y2 = oy * one + t2 * dy;
		if (x2 * x2 + y2 * y2 <= (wide_t'(1) <<< (4 * FB)))
			return make_hit(SURF_CAP, t2);
		return miss;
	endfunction

	task automatic report(input string what);
		$display("tb: mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	assign pending = expected_hits.size();
	assign mismatches = mismatch_count;

	always @(posedge clk or negedge arst_n) begin
		hit_rec_t e;
		if (!arst_n) begin
			expected_hits.delete();
		end else begin
			if (start && !busy)
				expected_hits.push_back(intersect_ray(origin_x, origin_y, origin_z,
					dir_x, dir_y, dir_z));
			if (done) begin
				if (expected_hits.size() == 0) begin
					report("result with no item waiting");
				end else begin
					e = expected_hits.pop_front();
					if (hit !== e.hit)
						report($sformatf("hit %b, expected %b", hit, e.hit));
					if (surface !== e.surface)
						report($sformatf("surface %b, expected %b", surface, e.surface));
					if (distance !== e.distance)
						report($sformatf("distance %0d, expected %0d", distance,
							e.distance));
					if (clipped !== e.clipped)
						report($sformatf("clipped %b, expected %b", clipped, e.clipped));
				end
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Ray capped cylinder testbench
// Drives directed and random rays with random sender gaps, lets the checker
// predict and compare each result, and prints the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = rcci_pkg::CW;
	localparam logic signed [CW-1:0] DIST_MAX = rcci_pkg::DIST_MAX;
	localparam logic signed [CW-1:0] DIST_MIN = rcci_pkg::DIST_MIN;
	localparam int RANDOM_RAYS = 1530;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 2 * rcci_pkg::LATENCY;
	localparam logic signed [CW-1:0] ONE = 32'sd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic done, hit, surface, clipped;
	logic signed [CW-1:0] distance;
	int mismatches, pending;
	int gap_pct = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	ray_capped_cylinder_intersection u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.done(done), .hit(hit), .surface(surface), .distance(distance),
		.clipped(clipped)
	);

	tb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.done(done), .hit(hit), .surface(surface), .distance(distance),
		.clipped(clipped), .mismatches(mismatches), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_ray(input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
			input logic signed [CW-1:0] oz, input logic signed [CW-1:0] dx,
			input logic signed [CW-1:0] dy, input logic signed [CW-1:0] dz);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		origin_x <= ox;
		origin_y <= oy;
		origin_z <= oz;
		dir_x <= dx;
		dir_y <= dy;
		dir_z <= dz;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic logic signed [CW-1:0] near_coord(input int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [CW-1:0] any_coord();
		case ($urandom_range(5))
			0: return DIST_MAX;
			1: return DIST_MIN;
			2: return '0;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic random_ray();
		logic signed [CW-1:0] v[6];
		int kind;
		kind = $urandom_range(99);
		for (int i = 0; i < 6; i++) begin
			if (kind < 70)
				v[i] = near_coord(i < 3 ? 4 * 65536 : 2 * 65536);
			else if (kind < 80)
				v[i] = near_coord(i < 3 ? 4 * 65536 : 64);
			else
				v[i] = any_coord();
		end
		if (kind < 70 && $urandom_range(3) == 0) begin
			v[3] = -v[0] + near_coord(32768);
			v[4] = -v[1] + near_coord(32768);
			v[5] = -v[2] + near_coord(32768);
		end
		if ($urandom_range(9) == 0) begin
			v[3] = '0;
			v[4] = '0;
		end
		if ($urandom_range(9) == 0)
			v[5] = '0;
		send_ray(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 15;
		send_ray('0, '0, '0, '0, '0, '0);
		send_ray(-3 * ONE, '0, '0, ONE, '0, '0);
		send_ray(3 * ONE, '0, ONE / 2, -ONE, '0, '0);
		send_ray('0, '0, -3 * ONE, '0, '0, ONE);
		send_ray('0, '0, 3 * ONE, '0, '0, -ONE);
		send_ray(ONE / 4, ONE / 4, 5 * ONE, '0, '0, '0);
		send_ray(3 * ONE, 3 * ONE, '0, ONE, '0, '0);
		send_ray(-3 * ONE, '0, 5 * ONE, ONE, '0, '0);
		send_ray('0, '0, -3 * ONE, '0, '0, 32'sd1);
		send_ray(-2 * ONE, '0, '0, 32'sd1, '0, '0);
		send_ray(3 * ONE, '0, '0, ONE, '0, '0);
		send_ray('0, '0, '0, ONE, ONE, '0);
		send_ray(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX);
		send_ray(DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN);
		send_ray(DIST_MIN, '0, '0, DIST_MAX, '0, '0);
		send_ray('0, '0, DIST_MIN, '0, '0, 32'sd1);
		send_ray(ONE, '0, ONE, '0, ONE, '0);
		send_ray(-ONE / 2, ONE / 2, -ONE / 2, 32'sd3, -32'sd7, 32'sd5);
		send_ray('0, '0, 2 * ONE, ONE, ONE, -ONE);
		send_ray(-1, -1, -1, -1, -1, -1);
		for (int i = 0; i < RANDOM_RAYS; i++) begin
			if (i == RANDOM_RAYS / 3) begin
				drain();
				gap_pct = 69;
			end else if (i == 2 * RANDOM_RAYS / 3) begin
				drain();
				gap_pct = 0;
			end
			random_ray();
		end
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
